@@ hdl/aes192_pkg.sv @@
// Package with the AES-192 types, constants, S-box tables and GF(2^8) helpers.
package aes192_pkg;

  localparam int NumRounds   = 12;
  localparam int NumEntries  = 26;
  localparam int EntryAw     = 5;
  localparam int RoundAw     = 4;
  localparam int CfgAw       = 3;

  localparam logic [CfgAw-1:0] CfgKey0 = 3'd0;
  localparam logic [CfgAw-1:0] CfgKey1 = 3'd1;
  localparam logic [CfgAw-1:0] CfgKey2 = 3'd2;
  localparam logic [CfgAw-1:0] CfgMode = 3'd3;

  typedef struct packed {
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3, u, v;
    a0 = w[7:0];
    a1 = w[15:8];
    a2 = w[23:16];
    a3 = w[31:24];
    if (inv) begin
      u  = xtime(xtime(a0 ^ a2));
      v  = xtime(xtime(a1 ^ a3));
      a0 = a0 ^ u;
      a1 = a1 ^ v;
      a2 = a2 ^ u;
      a3 = a3 ^ v;
    end
    b0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
    b1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
    b2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
    b3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    return {b3, b2, b1, b0};
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

@@ hdl/aes192_block_cipher_top.sv @@
// AES-192 block cipher top level with key schedule memories and a shared round unit.
//
// Usage: write the three key registers and the mode register over the plain
// write port while the block is idle. A key write marks the schedule stale; the
// next block then first runs the key expansion, which fills the forward and the
// inverse round key memories, two key words per cycle. Blocks enter on the input
// channel when in_valid_i is high and in_stall_o is low. Each block first reads
// the initial round key from memory as it enters, then makes 13 passes through
// the round unit, one round key read from memory per cycle.
// The result sits in an output register until the transfer on the output
// channel completes; a new block may enter while it waits.
// If the receiver stalls, the finished block holds in the final round and the
// block accepts no further item until the output register frees up.
// Reset clears all key and mode registers to zero and marks the schedule stale;
// the key memories are not cleared and are always filled before use.
module aes192_block_cipher_top
  import aes192_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgAw-1:0] cfg_addr_i,
  input  logic [63:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExpand,
    StRun
  } state_e;

  state_e                  state_q;
  logic                    ready_q;
  logic                    mode_q;
  logic [63:0]             key0_q, key1_q, key2_q;
  logic [31:0]             win_q [6];
  logic [EntryAw-1:0]      ecnt_q;
  logic [1:0]              phase_q;
  logic [7:0]              rcon_q;
  logic [RoundAw-1:0]      rnd_q;
  logic [127:0]            blk_q;
  logic [63:0]             rd_lo_q, rd_hi_q;
  logic                    out_valid_q;
  out_item_t               out_q;
  logic [63:0]             fwd_mem [NumEntries];
  logic [63:0]             inv_mem [NumEntries];

  logic                    in_fire;
  logic                    key_wr;
  logic [31:0]             new_w0, new_w1, tw;
  logic [63:0]             fwd_entry, inv_entry;
  logic [EntryAw-1:0]      inv_addr;
  logic [127:0]            sub_blk, mix_blk, rnd_blk;
  logic [RoundAw-1:0]      rnd_nxt;
  logic                    last_rnd;

  assign in_stall_o  = !(state_q == StIdle && ready_q);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign key_wr      = cfg_we_i && (cfg_addr_i == CfgKey0 || cfg_addr_i == CfgKey1 ||
                                    cfg_addr_i == CfgKey2);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rnd_nxt     = rnd_q + RoundAw'(1);
  assign last_rnd    = (rnd_q == RoundAw'(NumRounds));

  always_comb begin
    tw = win_q[5];
    if (phase_q == 2'd0) begin
      tw = sub_word({win_q[5][7:0], win_q[5][31:8]}) ^ {24'd0, rcon_q};
    end
    new_w0 = win_q[0] ^ tw;
    new_w1 = win_q[1] ^ new_w0;
    if (ecnt_q == EntryAw'(0)) begin
      fwd_entry = {win_q[1], win_q[0]};
    end else if (ecnt_q == EntryAw'(1)) begin
      fwd_entry = {win_q[3], win_q[2]};
    end else if (ecnt_q == EntryAw'(2)) begin
      fwd_entry = {win_q[5], win_q[4]};
    end else begin
      fwd_entry = {new_w1, new_w0};
    end
    inv_entry = fwd_entry;
    if (ecnt_q >= EntryAw'(2) && ecnt_q < EntryAw'(24)) begin
      inv_entry = {mix_col(fwd_entry[63:32], 1'b1), mix_col(fwd_entry[31:0], 1'b1)};
    end
    inv_addr = EntryAw'(24) - {ecnt_q[EntryAw-1:1], 1'b0} + {4'd0, ecnt_q[0]};
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (mode_q) begin
          sub_blk[8*(r+4*c)+:8] = INV_SBOX[blk_q[8*(r+4*((c-r)&3))+:8]];
        end else begin
          sub_blk[8*(r+4*c)+:8] = SBOX[blk_q[8*(r+4*((c+r)&3))+:8]];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      mix_blk[32*c+:32] = last_rnd ? sub_blk[32*c+:32] : mix_col(sub_blk[32*c+:32], mode_q);
    end
    if (rnd_q == '0) begin
      rnd_blk = blk_q ^ {rd_hi_q, rd_lo_q};
    end else begin
      rnd_blk = mix_blk ^ {rd_hi_q, rd_lo_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StExpand) begin
      fwd_mem[ecnt_q]   <= fwd_entry;
      inv_mem[inv_addr] <= inv_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_lo_q <= mode_q ? inv_mem[0] : fwd_mem[0];
      rd_hi_q <= mode_q ? inv_mem[1] : fwd_mem[1];
    end else if (state_q == StRun && !last_rnd) begin
      rd_lo_q <= mode_q ? inv_mem[{rnd_nxt, 1'b0}] : fwd_mem[{rnd_nxt, 1'b0}];
      rd_hi_q <= mode_q ? inv_mem[{rnd_nxt, 1'b1}] : fwd_mem[{rnd_nxt, 1'b1}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ready_q     <= 1'b0;
      mode_q      <= 1'b0;
      key0_q      <= '0;
      key1_q      <= '0;
      key2_q      <= '0;
      ecnt_q      <= '0;
      phase_q     <= '0;
      rcon_q      <= 8'h01;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StRun && last_rnd && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (key_wr) begin
        ready_q <= 1'b0;
      end else if (state_q == StExpand && ecnt_q == EntryAw'(NumEntries - 1)) begin
        ready_q <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgKey0: key0_q <= cfg_wdata_i;
          CfgKey1: key1_q <= cfg_wdata_i;
          CfgKey2: key2_q <= cfg_wdata_i;
          CfgMode: mode_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && !ready_q) begin
            state_q <= StExpand;
            ecnt_q  <= '0;
            phase_q <= '0;
            rcon_q  <= 8'h01;
          end else if (in_fire) begin
            state_q <= StRun;
            rnd_q   <= '0;
          end
        end
        StExpand: begin
          ecnt_q <= ecnt_q + EntryAw'(1);
          if (ecnt_q >= EntryAw'(3)) begin
            phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
            if (phase_q == 2'd0) begin
              rcon_q <= xtime(rcon_q);
            end
          end
          if (ecnt_q == EntryAw'(NumEntries - 1)) begin
            state_q <= StIdle;
          end
        end
        StRun: begin
          if (!last_rnd) begin
            rnd_q <= rnd_nxt;
          end else if (!out_valid_q || !out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && !ready_q) begin
      win_q[0] <= key0_q[31:0];
      win_q[1] <= key0_q[63:32];
      win_q[2] <= key1_q[31:0];
      win_q[3] <= key1_q[63:32];
      win_q[4] <= key2_q[31:0];
      win_q[5] <= key2_q[63:32];
    end else if (state_q == StExpand && ecnt_q >= EntryAw'(3)) begin
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= win_q[i+2];
      end
      win_q[4] <= new_w0;
      win_q[5] <= new_w1;
    end
    if (in_fire) begin
      blk_q <= in_data_i;
    end else if (state_q == StRun && !last_rnd) begin
      blk_q <= rnd_blk;
    end
    if (state_q == StRun && last_rnd && (!out_valid_q || !out_stall_i)) begin
      out_q <= rnd_blk;
    end
  end

endmodule
